### design/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder.
// Holds register indices, reset values, the packet position type and the motion scaling function.
// Used by ps2_mouse_packet_decoder_core.
package ps2md_pkg;

  localparam int GapW    = 8;
  localparam int AccelW  = 11;
  localparam int TimeW   = 32;
  localparam int MoveW   = 12;
  localparam int BtnW    = 3;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = AccelW;

  localparam logic [GapW-1:0]   GAP_RESET   = 8'd5;
  localparam logic [AccelW-1:0] ACCEL_RESET = 11'd10;

  localparam int SIGN_X_BIT = 4;
  localparam int SIGN_Y_BIT = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAP_MS = 1'b0,
    REG_ACCEL  = 1'b1
  } cfg_reg_t;

  // bytes of the current packet held so far
  typedef enum logic [1:0] {
    POS_IDLE = 2'd0,
    POS_HDR  = 2'd1,
    POS_X    = 2'd2
  } pkt_pos_t;

  // 9-bit motion, times 4, doubled when the magnitude of the times-4 value is above thr
  function automatic logic [MoveW-1:0] scale_motion(input logic [7:0] lo, input logic neg,
                                                     input logic [AccelW-1:0] thr);
    logic [MoveW-1:0] ext;
    logic [MoveW-1:0] mag;
    begin
      ext = {{(MoveW-11){neg}}, neg, lo, 2'b00};
      mag = ext[MoveW-1] ? (~ext + 12'd1) : ext;
      if (mag > {1'b0, thr}) begin
        scale_motion = {ext[MoveW-2:0], 1'b0};
      end else begin
        scale_motion = ext;
      end
    end
  endfunction

endpackage

### design/ps2_mouse_packet_decoder_core.sv
// PS/2 mouse packet decoder top level: packet assembly, resync on byte gap, motion scaling.
// Depends on ps2md_pkg.
//
// Takes one mouse byte per word with its millisecond time stamp and emits one word per
// complete three-byte packet (header, X, Y). A byte starts a new packet when none is in
// progress, or when its time is later than the previous byte's by more than gap_ms.
// Decoding runs in one pass from the packet registers into an output register, so a byte
// can be taken every clock; the input stalls only while that output register is full and
// not taken.
// Output motion is the 9-bit value times 4, doubled when the magnitude of that times-4 value exceeds accel_threshold.
module ps2_mouse_packet_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [39:0]                   s_tdata,   // rx_byte[7:0], time_ms[39:8]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // buttons[2:0], move_x[14:3], move_y[26:15]
  input  logic                          cfg_we,
  input  logic [ps2md_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ps2md_pkg::CfgW-1:0]    cfg_data
);
  import ps2md_pkg::*;

  logic [GapW-1:0]   gap_ms;
  logic [AccelW-1:0] accel_threshold;
  pkt_pos_t          pos;
  pkt_pos_t          pos_next;
  logic [7:0]        header_byte;
  logic [7:0]        x_byte;
  logic [TimeW-1:0]  last_time;

  logic [7:0]        rx_byte;
  logic [TimeW-1:0]  time_ms;
  logic [TimeW:0]    diff;
  logic              resync;
  logic              emit;
  logic              s_fire;

  logic [BtnW-1:0]   buttons;
  logic [MoveW-1:0]  move_x;
  logic [MoveW-1:0]  move_y;

  assign rx_byte  = s_tdata[7:0];
  assign time_ms  = s_tdata[39:8];
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  assign diff   = {1'b0, time_ms} - {1'b0, last_time};
  assign resync = (pos == POS_IDLE) || (pos != POS_HDR && pos != POS_X) ||
                  (!diff[TimeW] && (diff[TimeW-1:0] > {{(TimeW-GapW){1'b0}}, gap_ms}));
  assign emit   = !resync && (pos == POS_X);

  always_comb begin
    if (resync) begin
      pos_next = POS_HDR;
    end else if (pos == POS_HDR) begin
      pos_next = POS_X;
    end else begin
      pos_next = POS_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ms          <= GAP_RESET;
      accel_threshold <= ACCEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAP_MS: gap_ms          <= cfg_data[GapW-1:0];
        REG_ACCEL:  accel_threshold <= cfg_data[AccelW-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_IDLE;
      header_byte <= 8'd0;
      x_byte      <= 8'd0;
      last_time   <= '0;
    end else if (s_fire) begin
      pos       <= pos_next;
      last_time <= time_ms;
      if (resync) begin
        header_byte <= rx_byte;
      end else if (pos == POS_HDR) begin
        x_byte <= rx_byte;
      end
    end
  end

  assign buttons = {header_byte[1], header_byte[2], header_byte[0]};
  assign move_x  = scale_motion(x_byte, header_byte[SIGN_X_BIT], accel_threshold);
  assign move_y  = scale_motion(rx_byte, header_byte[SIGN_Y_BIT], accel_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && emit) begin
      m_tdata <= {5'd0, move_y, move_x, buttons};
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    s_fire && emit |=> m_tvalid)
    else $error("completed packet not presented");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    s_fire && !emit && m_tready |=> !m_tvalid)
    else $error("word emitted without a complete packet");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

endmodule
